[src/lbrle_pkg.sv]
`default_nettype none

package lbrle_pkg;

    // tile geometry
    localparam int MAX_TILE_SIDE = 64;
    localparam int SIDE_W        = 7;
    localparam int POS_W         = $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE);
    localparam int TOTAL_W       = $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE + 1);

    // pixel and run fields
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int LEN_W  = 8;
    localparam int TOL_W  = 10;
    localparam int DIST_W = 10;

    localparam logic [LEN_W-1:0]  RUN_LIMIT       = 8'd255;
    localparam logic [SIDE_W-1:0] TILE_SIDE_RESET = 7'd8;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_SIDE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 2'd1;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [LEN_W-1:0] length;
        logic             last;
    } run_t;

    // up to two runs produced by one pixel, in delivery order
    typedef struct packed {
        logic first_valid;
        logic second_valid;
        run_t first;
        run_t second;
    } push_t;

    // pixels per tile for a programmed side, side clamped to 1..MAX_TILE_SIDE
    function automatic logic [TOTAL_W-1:0] tile_total(input logic [SIDE_W-1:0] side);
        logic [SIDE_W-1:0]   s;
        logic [2*SIDE_W-1:0] prod;
        if (side == '0)
            s = SIDE_W'(1);
        else if (int'(side) > MAX_TILE_SIDE)
            s = SIDE_W'(MAX_TILE_SIDE);
        else
            s = side;
        prod = {{SIDE_W{1'b0}}, s} * {{SIDE_W{1'b0}}, s};
        return prod[TOTAL_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

[src/lbrle_fifo.sv]
`default_nettype none

module lbrle_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lbrle_pkg::push_t push,
    output logic                room,
    output logic                out_valid,
    input  wire logic           out_stall,
    output lbrle_pkg::run_t     head
);
    import lbrle_pkg::*;

    run_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg;
    logic [FIFO_AW-1:0] wptr_next;
    logic [FIFO_AW-1:0] rptr_reg;
    logic [FIFO_AW-1:0] rptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic [FIFO_CW-1:0] push_n;
    logic               pop;

    // space for two runs is needed before a pixel may be processed
    assign room      = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rptr_reg];
    assign pop       = out_valid && !out_stall;

    assign push_n = FIFO_CW'(push.first_valid) + FIFO_CW'(push.second_valid);

    // pointer and count update
    always_comb
    begin
        wptr_next  = wptr_reg + push_n[FIFO_AW-1:0];
        rptr_next  = rptr_reg + FIFO_AW'(pop);
        count_next = count_reg + push_n - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.first_valid)
            mem_reg[wptr_reg] <= push.first;
        if (push.second_valid)
            mem_reg[wptr_reg + FIFO_AW'(1)] <= push.second;
    end

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) + 32'(push_n)) <= FIFO_DEPTH)
        else $error("run queue overflow");

    a_pop_leaves_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_n == '0) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)))
        else $error("run queue count wrong after pop");

endmodule

`default_nettype wire

[src/lbrle_core.sv]
`default_nettype none

module lbrle_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lbrle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lbrle_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lbrle_pkg::CH_W-1:0]        pix_red,
    input  wire logic [lbrle_pkg::CH_W-1:0]        pix_green,
    input  wire logic [lbrle_pkg::CH_W-1:0]        pix_blue,
    input  wire logic                              room,
    output lbrle_pkg::push_t                       push
);
    import lbrle_pkg::*;

    // configuration
    logic [TOTAL_W-1:0] tile_total_reg;
    logic [TOL_W-1:0]   tolerance_reg;

    // input register
    logic               in_vld_reg;
    logic               in_vld_next;
    logic [PIX_W-1:0]   pix_reg;

    // encoder state
    logic [PIX_W-1:0]   prev_reg;
    logic [PIX_W-1:0]   colour_reg;
    logic [PIX_W-1:0]   colour_next;
    logic [LEN_W-1:0]   count_reg;
    logic [LEN_W-1:0]   count_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    logic               advance;
    logic               accept;
    logic               tile_start;
    logic               extend;
    logic               brk;
    logic               tile_end;
    logic [DIST_W-1:0]  diff_sum;
    logic [TOTAL_W-1:0] pos_inc;
    logic [LEN_W-1:0]   run_count;
    logic [PIX_W-1:0]   run_colour;
    run_t               broken_run;
    run_t               final_run;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_total_reg <= tile_total(TILE_SIDE_RESET);
            tolerance_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TILE_SIDE: tile_total_reg <= tile_total(cfg_data[SIDE_W-1:0]);
                REG_TOLERANCE: tolerance_reg  <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // input handshake: hold the pixel while the queue lacks room
    assign advance     = in_vld_reg && room;
    assign in_stall    = in_vld_reg && !room;
    assign accept      = in_valid && !in_stall;
    assign in_vld_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= {pix_red, pix_green, pix_blue};
    end

    // summed absolute channel difference to the previous pixel
    assign diff_sum = DIST_W'(abs_diff(prev_reg[3*CH_W-1:2*CH_W], pix_reg[3*CH_W-1:2*CH_W]))
                    + DIST_W'(abs_diff(prev_reg[2*CH_W-1:CH_W], pix_reg[2*CH_W-1:CH_W]))
                    + DIST_W'(abs_diff(prev_reg[CH_W-1:0], pix_reg[CH_W-1:0]));

    // run decision
    always_comb
    begin
        tile_start = (pos_reg == '0) || (count_reg == '0);
        extend     = !tile_start && (diff_sum <= tolerance_reg) && (count_reg < RUN_LIMIT);
        brk        = !tile_start && !extend;
        run_colour = extend ? colour_reg : pix_reg;
        run_count  = extend ? (count_reg + LEN_W'(1)) : LEN_W'(1);
        pos_inc    = TOTAL_W'(pos_reg) + TOTAL_W'(1);
        tile_end   = (pos_inc >= tile_total_reg);

        broken_run.red    = colour_reg[3*CH_W-1:2*CH_W];
        broken_run.green  = colour_reg[2*CH_W-1:CH_W];
        broken_run.blue   = colour_reg[CH_W-1:0];
        broken_run.length = count_reg;
        broken_run.last   = 1'b0;

        final_run.red    = run_colour[3*CH_W-1:2*CH_W];
        final_run.green  = run_colour[2*CH_W-1:CH_W];
        final_run.blue   = run_colour[CH_W-1:0];
        final_run.length = run_count;
        final_run.last   = 1'b1;

        push.first_valid  = advance && (brk || tile_end);
        push.second_valid = advance && brk && tile_end;
        push.first        = brk ? broken_run : final_run;
        push.second       = final_run;

        colour_next = run_colour;
        count_next  = tile_end ? '0 : run_count;
        pos_next    = tile_end ? '0 : pos_inc[POS_W-1:0];
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            colour_reg <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end
        else if (advance)
        begin
            prev_reg   <= pix_reg;
            colour_reg <= colour_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
        end
    end

    // checks
    a_open_run_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (pos_reg == '0))
        else $error("open run count and tile position disagree");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        push.first_valid |-> (push.first.length != '0))
        else $error("empty run emitted");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |-> (push.first_valid && !push.first.last && push.second.last))
        else $error("run pair out of order");

    a_tile_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tile_end) |=> (count_reg == '0))
        else $error("run still open after tile end");

endmodule

`default_nettype wire

[src/lossy_block_run_length_encoder.sv]
// channel   | direction | handshake              | payload
// cfg       | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
// pixel in  | in        | in_valid / in_stall    | pix_red, pix_green, pix_blue
// run out   | out       | out_valid / out_stall  | run_red, run_green, run_blue,
//           |           |                        | run_length, last_in_tile
//
// one pixel per clock is taken while in_stall is low; each pixel is registered when taken and decided
// once the queue has room, and its runs enter the run queue, ready at the output the cycle after that
// a pixel that yields two runs hands them out one after the other; the four-entry run queue
// must hold room for two runs, so in_stall rises while the queue is backed up
// reset clears the tile position and open run and loads side 8, tolerance 0
// configuration writes are always ready and take effect the next cycle
`default_nettype none

module lossy_block_run_length_encoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lbrle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lbrle_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lbrle_pkg::CH_W-1:0]        pix_red,
    input  wire logic [lbrle_pkg::CH_W-1:0]        pix_green,
    input  wire logic [lbrle_pkg::CH_W-1:0]        pix_blue,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [lbrle_pkg::CH_W-1:0]             run_red,
    output logic [lbrle_pkg::CH_W-1:0]             run_green,
    output logic [lbrle_pkg::CH_W-1:0]             run_blue,
    output logic [lbrle_pkg::LEN_W-1:0]            run_length,
    output logic                                   last_in_tile
);
    import lbrle_pkg::*;

    push_t push;
    run_t  head;
    logic  room;

    // run decision and tile bookkeeping
    lbrle_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pix_red   (pix_red),
        .pix_green (pix_green),
        .pix_blue  (pix_blue),
        .room      (room),
        .push      (push)
    );

    // run queue toward the output
    lbrle_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign run_red      = head.red;
    assign run_green    = head.green;
    assign run_blue     = head.blue;
    assign run_length   = head.length;
    assign last_in_tile = head.last;

endmodule

`default_nettype wire

[sim/tb_lossy_block_run_length_encoder.sv]
`timescale 1ns / 1ps

module tb_lossy_block_run_length_encoder;

    import lbrle_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 440;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [CH_W-1:0] pix_red = '0;
    logic [CH_W-1:0] pix_green = '0;
    logic [CH_W-1:0] pix_blue = '0;

    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [CH_W-1:0]  run_red;
    logic [CH_W-1:0]  run_green;
    logic [CH_W-1:0]  run_blue;
    logic [LEN_W-1:0] run_length;
    logic             last_in_tile;

    // pixels not yet taken by the block, front item is the one on the bus
    logic [PIX_W-1:0] pending_pixels[$];
    // runs the encoder must still deliver, oldest first
    run_t             expected_runs[$];
    run_t             due_run;

    // encoder state as predicted
    logic [SIDE_W-1:0] cfg_side = TILE_SIDE_RESET;
    logic [TOL_W-1:0]  cfg_tol = '0;
    logic [PIX_W-1:0]  enc_prev = '0;
    logic [PIX_W-1:0]  enc_colour = '0;
    logic [LEN_W-1:0]  enc_count = '0;
    logic [12:0]       enc_pos = '0;

    logic [PIX_W-1:0] gen_last = '0;
    int idle_pct = 25;
    int error_count = 0;

    lossy_block_run_length_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pix_red      (pix_red),
        .pix_green    (pix_green),
        .pix_blue     (pix_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .run_red      (run_red),
        .run_green    (run_green),
        .run_blue     (run_blue),
        .run_length   (run_length),
        .last_in_tile (last_in_tile)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [CH_W-1:0] chan_diff(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void close_run(input logic last);
        run_t r;
        r.red    = enc_colour[23:16];
        r.green  = enc_colour[15:8];
        r.blue   = enc_colour[7:0];
        r.length = enc_count;
        r.last   = last;
        expected_runs.push_back(r);
    endfunction

    // advance the predicted encoder by one pixel, queue the runs it closes
    function automatic void encode_pixel(input logic [PIX_W-1:0] pix);
        logic [SIDE_W-1:0] side;
        logic [12:0]       total;
        logic [9:0]        diff_sum;
        if (cfg_side == '0)
            side = 7'd1;
        else if (int'(cfg_side) > MAX_TILE_SIDE)
            side = 7'(MAX_TILE_SIDE);
        else
            side = cfg_side;
        total = side * side;
        diff_sum = chan_diff(enc_prev[23:16], pix[23:16])
                 + chan_diff(enc_prev[15:8], pix[15:8])
                 + chan_diff(enc_prev[7:0], pix[7:0]);
        if (enc_pos == 0 || enc_count == 0)
        begin
            enc_colour = pix;
            enc_count  = 8'd1;
        end
        else if (diff_sum <= cfg_tol && enc_count < RUN_LIMIT)
            enc_count = enc_count + 8'd1;
        else
        begin
            close_run(1'b0);
            enc_colour = pix;
            enc_count  = 8'd1;
        end
        enc_prev = pix;
        enc_pos  = enc_pos + 13'd1;
        if (enc_pos >= total)
        begin
            close_run(1'b1);
            enc_count = '0;
            enc_pos   = '0;
        end
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                encode_pixel({pix_red, pix_green, pix_blue});
                pending_pixels.delete(0);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    {pix_red, pix_green, pix_blue} <= pending_pixels[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // run monitor and output back-pressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_runs.size() == 0)
                note_error($sformatf("unexpected run: rgb %02h%02h%02h len %0d last %0b",
                                     run_red, run_green, run_blue, run_length,
                                     last_in_tile));
            else
            begin
                due_run = expected_runs.pop_front();
                if (run_red !== due_run.red || run_green !== due_run.green ||
                    run_blue !== due_run.blue || run_length !== due_run.length ||
                    last_in_tile !== due_run.last)
                    note_error($sformatf({"run mismatch: expected rgb %02h%02h%02h len %0d ",
                                          "last %0b, got rgb %02h%02h%02h len %0d last %0b"},
                                         due_run.red, due_run.green, due_run.blue,
                                         due_run.length, due_run.last, run_red, run_green,
                                         run_blue, run_length, last_in_tile));
            end
        end
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    // wait until every pixel is taken and every run delivered, then let the pipe empty
    task automatic settle();
        while (pending_pixels.size() != 0 || expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_TILE_SIDE)
            cfg_side = data[SIDE_W-1:0];
        else if (idx == REG_TOLERANCE)
            cfg_tol = data[TOL_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // queue a stretch of pixels: repeats, near neighbours and fully random ones
    task automatic feed(input int count, input int spread, input int keep_permille);
        logic [PIX_W-1:0] p;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(999) < keep_permille)
                p = gen_last;
            else if ($urandom_range(1) == 0)
            begin
                for (int c = 0; c < 3; c++)
                    p[8*c +: 8] = gen_last[8*c +: 8]
                                + 8'(int'($urandom_range(2 * spread)) - spread);
            end
            else
                p = PIX_W'($urandom);
            pending_pixels.push_back(p);
            gen_last = p;
        end
        settle();
    endtask

    // stimulus
    initial
    begin
        int fed;
        int phase;
        logic [SIDE_W-1:0] side;
        logic [TOL_W-1:0]  tol;
        fed = 0;
        phase = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: equal pixels merge, any change breaks, first pixel opens
        pending_pixels = {24'h000000, 24'h000000, 24'hffffff, 24'hffffff, 24'h010000};
        settle();
        // shrink the tile mid-tile, it closes on the next pixel
        write_reg(REG_TILE_SIDE, 10'd2);
        pending_pixels = {24'h0000ff};
        settle();
        // tolerance at the full-swing distance and above
        write_reg(REG_TOLERANCE, 10'd765);
        pending_pixels = {24'h000000, 24'hffffff, 24'h00ff00, 24'h123456};
        settle();
        write_reg(REG_TOLERANCE, 10'h3ff);
        pending_pixels = {24'hff00ff, 24'h00ff00, 24'hffffff, 24'h000000};
        settle();
        // distance exactly at tolerance merges, one above breaks, two runs on tile end
        write_reg(REG_TOLERANCE, 10'd10);
        pending_pixels = {24'h102030, 24'h152530, 24'h152531, 24'h0a2531};
        settle();
        // spare indexes are ignored, zero side acts as one pixel per tile
        write_reg(REG_SPARE_2, 10'h3ff);
        write_reg(REG_SPARE_3, 10'h155);
        write_reg(REG_TILE_SIDE, 10'h380);
        pending_pixels = {24'habcdef, 24'h123456};
        settle();

        // random phases, sometimes keeping a setting or a partial tile across phases
        while (fed < RANDOM_ITEMS)
        begin
            case ($urandom_range(7))
                0: side = 7'd0;
                1: side = 7'd1;
                2: side = 7'd2;
                3: side = 7'd3;
                4: side = 7'd4;
                5: side = 7'd8;
                default: side = 7'($urandom_range(1, 12));
            endcase
            case ($urandom_range(5))
                0: tol = 10'd0;
                1: tol = 10'd765;
                2: tol = 10'h3ff;
                3: tol = 10'($urandom_range(1023));
                default: tol = 10'($urandom_range(30));
            endcase
            if ($urandom_range(3) != 0)
                write_reg(REG_TILE_SIDE, {3'($urandom_range(7)), side});
            if ($urandom_range(3) != 0)
                write_reg(REG_TOLERANCE, tol);
            if ($urandom_range(9) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                          10'($urandom_range(1023)));
            idle_pct = (phase == 6) ? 0 : 25;
            begin
                int n;
                n = $urandom_range(10, 80);
                feed(n, $urandom_range(1, 8), 300);
                fed += n;
            end
            phase++;
        end

        // close any partial tile left by the random phases
        write_reg(REG_TILE_SIDE, 10'd1);
        idle_pct = 25;
        feed(1, 8, 300);
        // run limit hit on the very pixel that ends the tile
        write_reg(REG_TILE_SIDE, 10'd16);
        write_reg(REG_TOLERANCE, 10'd765);
        feed(256, 8, 300);
        // run limit inside a tile, with a long stretch of no gaps on either side
        write_reg(REG_TILE_SIDE, 10'd17);
        write_reg(REG_TOLERANCE, 10'h3ff);
        idle_pct = 0;
        feed(289, 8, 300);
        // oversized side saturates to the largest tile, so no tile closes early
        write_reg(REG_TILE_SIDE, 10'h07f);
        write_reg(REG_TOLERANCE, 10'd765);
        idle_pct = 25;
        feed(300, 2, 998);
        // grow-then-shrink mid-tile: the tile closes once the new size is reached
        write_reg(REG_TILE_SIDE, 10'd18);
        feed(24, 2, 998);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
src/lbrle_pkg.sv
src/lbrle_fifo.sv
src/lbrle_core.sv
src/lossy_block_run_length_encoder.sv
sim/tb_lossy_block_run_length_encoder.sv
